// ----- hw/rtl/lda_pkg.sv -----
// Shared types and constants of the line detect and align sequencer.
package lda_pkg;

  // Sequence phase, one-hot encoded.
  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_DRIVE       = 9'b000000010,
    PH_BRAKE       = 9'b000000100,
    PH_BRAKE_WAIT  = 9'b000001000,
    PH_CHECK       = 9'b000010000,
    PH_BACKUP      = 9'b000100000,
    PH_BACKUP_WAIT = 9'b001000000,
    PH_SETTLE      = 9'b010000000,
    PH_ALIGN       = 9'b100000000
  } phase_e;

  // Numeric phase codes as reported on the result word.
  localparam logic [3:0] PHC_IDLE        = 4'd0;
  localparam logic [3:0] PHC_DRIVE       = 4'd1;
  localparam logic [3:0] PHC_BRAKE       = 4'd2;
  localparam logic [3:0] PHC_BRAKE_WAIT  = 4'd3;
  localparam logic [3:0] PHC_CHECK       = 4'd4;
  localparam logic [3:0] PHC_BACKUP      = 4'd5;
  localparam logic [3:0] PHC_BACKUP_WAIT = 4'd6;
  localparam logic [3:0] PHC_SETTLE      = 4'd7;
  localparam logic [3:0] PHC_ALIGN       = 4'd8;

  // Input word kinds.
  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Motor commands.
  typedef enum logic [2:0] {
    MC_HOLD   = 3'd0,
    MC_FWD    = 3'd1,
    MC_BRAKE  = 3'd2,
    MC_STOP   = 3'd3,
    MC_REV    = 3'd4,
    MC_ALEFT  = 3'd5,
    MC_ARIGHT = 3'd6,
    MC_RSVD   = 3'd7
  } motor_e;

  // Drive level requests.
  typedef enum logic [1:0] {
    DL_SAME  = 2'd0,
    DL_CRAWL = 2'd1,
    DL_OFF   = 2'd2,
    DL_RSVD  = 2'd3
  } drive_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_ON    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_ON   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_BLACK = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_BLACK = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BACKUP     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE     = 3'd5;

  // Register widths and reset values.
  localparam int unsigned LevelW = 12;
  localparam int unsigned TicksW = 16;
  localparam logic [LevelW-1:0] LeftOnRst     = 12'd2048;
  localparam logic [LevelW-1:0] RightOnRst    = 12'd2048;
  localparam logic [LevelW-1:0] LeftBlackRst  = 12'd3000;
  localparam logic [LevelW-1:0] RightBlackRst = 12'd3000;
  localparam logic [TicksW-1:0] BackupRst     = 16'd100;
  localparam logic [TicksW-1:0] SettleRst     = 16'd200;

  // Default parameter values.
  localparam int unsigned SampleBitsDef = 12;
  localparam int unsigned TimerBitsDef  = 16;

  // Result word layout.
  localparam int unsigned OutBits = 14;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  // Phase to its numeric code.
  function automatic logic [3:0] phase_code(phase_e ph);
    logic [3:0] c;
    c = PHC_IDLE;
    unique case (ph)
      PH_IDLE:        c = PHC_IDLE;
      PH_DRIVE:       c = PHC_DRIVE;
      PH_BRAKE:       c = PHC_BRAKE;
      PH_BRAKE_WAIT:  c = PHC_BRAKE_WAIT;
      PH_CHECK:       c = PHC_CHECK;
      PH_BACKUP:      c = PHC_BACKUP;
      PH_BACKUP_WAIT: c = PHC_BACKUP_WAIT;
      PH_SETTLE:      c = PHC_SETTLE;
      PH_ALIGN:       c = PHC_ALIGN;
      default:        c = PHC_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/line_detect_align_sequencer.sv -----
// Line approach sequencer: input register, state update, result register.
//
// Usage: each word on the slave stream is a start, stop or step item, with the
// kind in s_axis_tuser and the sensor samples and flags in s_axis_tdata. Every
// accepted word yields exactly one result word on the master stream carrying
// the motor command, drive level, phase and status flags.
// An accepted word is held in the input register, and the state update loads
// the result register from it once the result register is free to take a new
// word. Throughput is one word per clock while the receiver does not stall; the
// state update is a single compare-and-select stage over the phase register,
// timer and thresholds.
// When the receiver stalls, the result register holds its word, the input
// register keeps the next word, and s_axis_tready drops once both are full.
// Reset (rst_ni low) empties both registers, puts the phase at idle, clears
// the timer and the first-crossing flags, enables external commands and loads
// the default thresholds and tick counts. Configuration writes through
// cfg_we_i take effect at the next clock edge and are expected only while no
// word is in flight.
module line_detect_align_sequencer #(
  parameter int unsigned SAMPLE_BITS = lda_pkg::SampleBitsDef,
  parameter int unsigned TIMER_BITS  = lda_pkg::TimerBitsDef,
  localparam int unsigned InBits = 2 * SAMPLE_BITS + 5,
  localparam int unsigned InW    = ((InBits + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [lda_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lda_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata fields from bit 0: left_sample, right_sample, tick, brake_active,
  // switch_pressed, safety_halt, calibrated, zero fill
  input  logic [InW-1:0]                s_axis_tdata,
  // tuser fields from bit 0: kind
  input  logic [1:0]                    s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata fields from bit 0: motor_command, drive_level, phase_out, running,
  // commands_allowed, start_refused, aligned_done, aborted, zero fill
  output logic [lda_pkg::OutW-1:0]      m_axis_tdata
);
  import lda_pkg::*;

  localparam int unsigned CmpW  = (SAMPLE_BITS > LevelW) ? SAMPLE_BITS : LevelW;
  localparam int unsigned TCmpW = (TIMER_BITS > TicksW) ? TIMER_BITS : TicksW;

  // Configuration registers.
  logic [LevelW-1:0] left_on_q, right_on_q, left_black_q, right_black_q;
  logic [TicksW-1:0] backup_q, settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_on_q     <= LeftOnRst;
      right_on_q    <= RightOnRst;
      left_black_q  <= LeftBlackRst;
      right_black_q <= RightBlackRst;
      backup_q      <= BackupRst;
      settle_q      <= SettleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEFT_ON:     left_on_q     <= cfg_wdata_i[LevelW-1:0];
        CFG_RIGHT_ON:    right_on_q    <= cfg_wdata_i[LevelW-1:0];
        CFG_LEFT_BLACK:  left_black_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_RIGHT_BLACK: right_black_q <= cfg_wdata_i[LevelW-1:0];
        CFG_BACKUP:      backup_q      <= cfg_wdata_i[TicksW-1:0];
        CFG_SETTLE:      settle_q      <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic                   in_vld_q;
  logic [InBits-1:0]      in_data_q;
  kind_e                  in_kind_q;
  logic                   advance;

  assign advance       = in_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[InBits-1:0];
      in_kind_q <= kind_e'(s_axis_tuser);
    end
  end

  // Unpack the registered word.
  logic [SAMPLE_BITS-1:0] ls, rs;
  logic tick, brk, sw, halt, cal;

  assign ls   = in_data_q[SAMPLE_BITS-1:0];
  assign rs   = in_data_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign tick = in_data_q[2*SAMPLE_BITS];
  assign brk  = in_data_q[2*SAMPLE_BITS+1];
  assign sw   = in_data_q[2*SAMPLE_BITS+2];
  assign halt = in_data_q[2*SAMPLE_BITS+3];
  assign cal  = in_data_q[2*SAMPLE_BITS+4];

  // Sequencer state.
  phase_e                phase_q, phase_d;
  logic                  active_q, active_d;
  logic                  first_l_q, first_l_d;
  logic                  first_r_q, first_r_d;
  logic                  cmd_en_q, cmd_en_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;

  // Sensor compares against the configured levels.
  logic lon, ron, lx, rx, backup_done, settle_done;

  assign lon = CmpW'(ls) > CmpW'(left_on_q);
  assign ron = CmpW'(rs) > CmpW'(right_on_q);
  assign lx  = CmpW'(ls) > CmpW'(left_black_q);
  assign rx  = CmpW'(rs) > CmpW'(right_black_q);

  // Timer after the tick of this word, saturating at all ones.
  logic [TIMER_BITS-1:0] ticks_adv;

  assign ticks_adv = (tick && !(&ticks_q)) ? ticks_q + TIMER_BITS'(1) : ticks_q;
  assign backup_done = TCmpW'(ticks_adv) > TCmpW'(backup_q);
  assign settle_done = TCmpW'(ticks_adv) > TCmpW'(settle_q);

  // Next state and result fields.
  motor_e mc;
  drive_e dl;
  logic   refused, aligned, aborted;

  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    first_l_d = first_l_q;
    first_r_d = first_r_q;
    cmd_en_d  = cmd_en_q;
    ticks_d   = ticks_q;
    mc        = MC_HOLD;
    dl        = DL_SAME;
    refused   = 1'b0;
    aligned   = 1'b0;
    aborted   = 1'b0;

    unique case (in_kind_q)
      KIND_START: begin
        if (!cal) begin
          refused = 1'b1;
        end else begin
          phase_d   = PH_DRIVE;
          cmd_en_d  = 1'b0;
          active_d  = 1'b1;
          first_l_d = 1'b0;
          first_r_d = 1'b0;
          ticks_d   = '0;
          dl        = DL_CRAWL;
          mc        = MC_FWD;
        end
      end
      KIND_STOP: begin
        active_d = 1'b0;
        phase_d  = PH_IDLE;
        mc       = MC_STOP;
        dl       = DL_OFF;
      end
      KIND_STEP: begin
        ticks_d = ticks_adv;
        if (active_q && !halt) begin
          if (sw) begin
            // Switch press ends the run before any phase action.
            mc       = MC_STOP;
            active_d = 1'b0;
            phase_d  = PH_IDLE;
            aborted  = 1'b1;
          end else begin
            unique case (phase_q)
              PH_DRIVE: begin
                mc = MC_FWD;
                if (lx || rx) begin
                  if (lx && !first_l_q && !first_r_q) first_l_d = 1'b1;
                  if (rx && !first_r_q && !first_l_q) first_r_d = 1'b1;
                  phase_d = PH_BRAKE;
                  ticks_d = '0;
                end
              end
              PH_BRAKE: begin
                mc      = MC_BRAKE;
                phase_d = PH_BRAKE_WAIT;
              end
              PH_BRAKE_WAIT: begin
                if (!brk) begin
                  mc      = MC_STOP;
                  phase_d = PH_CHECK;
                  ticks_d = '0;
                end
              end
              PH_CHECK: begin
                mc = MC_STOP;
                if (lon || ron) begin
                  phase_d = PH_ALIGN;
                end else begin
                  phase_d = PH_BACKUP;
                  ticks_d = '0;
                  dl      = DL_CRAWL;
                end
              end
              PH_BACKUP: begin
                mc      = MC_REV;
                phase_d = PH_BACKUP_WAIT;
                ticks_d = '0;
              end
              PH_BACKUP_WAIT: begin
                if (backup_done) begin
                  mc      = MC_STOP;
                  phase_d = PH_SETTLE;
                  ticks_d = '0;
                end
              end
              PH_SETTLE: begin
                if (settle_done) begin
                  phase_d = (lon || ron) ? PH_ALIGN : PH_BACKUP;
                end
              end
              PH_ALIGN: begin
                priority if (lon && ron) begin
                  mc       = MC_STOP;
                  phase_d  = PH_IDLE;
                  active_d = 1'b0;
                  cmd_en_d = 1'b1;
                  aligned  = 1'b1;
                end else if (lon) begin
                  mc = MC_ALEFT;
                end else if (ron) begin
                  mc = MC_ARIGHT;
                end else if (first_l_q) begin
                  mc = MC_ALEFT;
                end else if (first_r_q) begin
                  mc = MC_ARIGHT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // State update, one word per advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      active_q  <= 1'b0;
      first_l_q <= 1'b0;
      first_r_q <= 1'b0;
      cmd_en_q  <= 1'b1;
      ticks_q   <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      active_q  <= active_d;
      first_l_q <= first_l_d;
      first_r_q <= first_r_d;
      cmd_en_q  <= cmd_en_d;
      ticks_q   <= ticks_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= OutW'({aborted, aligned, refused, cmd_en_d, active_d,
                             phase_code(phase_d), dl, mc});
    end
  end

endmodule
